// ===== hdl/sbbo_pkg.sv =====
// Shared types and constants of the sparse bitmap bit operations unit.
package sbbo_pkg;

    localparam int IDX_BITS     = 12;
    localparam int REQ_BITS     = 2;
    localparam int POS_W        = IDX_BITS - 3;
    localparam int WORDS_USED_W = 6;
    localparam int S_DATA_W     = 16;
    localparam int M_DATA_W     = 8;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_TEST  = 2'd2,
        REQ_FLUSH = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_OR_BIT,
        CELL_AND_NOT,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_FLUSH
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SPLIT,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
    } t_cell_stat;

endpackage

// ===== hdl/sparse_bitmap_bit_ops_unit.sv =====
// Top level of the sparse bitmap bit operations unit: control, index split, cell chain and output register.
//
//  Channel  Direction  Handshake            Payload (low bit first)
//  s_       in         s_tvalid, s_tready   s_tdata: req_type[1:0], bit_index[13:2]
//  m_       out        m_tvalid, m_tready   m_tdata: bit_value[0], status[1], words_used[7:2]
//
// An item is accepted in the idle state; the control then steps through the decode and split
// states while the index split registers its stages, and in the execute state the cell chain
// updates and the result is loaded into the output register.
// A new item is accepted only when the previous one has reached the output register.
// A result that is not taken holds the unit in its last stage.
// The synchronous reset clears the cell valid bits, the word count and the output valid,
// and returns the control to the idle state.
module sparse_bitmap_bit_ops_unit #(
    parameter int WORD_BITS   = 64,
    parameter int MASK_WORDS  = 64,
    parameter int STORE_WORDS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sbbo_pkg::S_DATA_W-1:0]   s_tdata,  // req_type, bit_index, zero fill
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sbbo_pkg::M_DATA_W-1:0]   m_tdata   // bit_value, status, words_used
);

    localparam int TAG_W  = $clog2(MASK_WORDS);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int CNT_W  = $clog2(STORE_WORDS + 1);
    localparam int WU_W   = sbbo_pkg::WORDS_USED_W;
    localparam int REQ_W  = sbbo_pkg::REQ_BITS;
    localparam int IDX_W  = sbbo_pkg::IDX_BITS;
    localparam int MDAT_W = sbbo_pkg::M_DATA_W;

    sbbo_pkg::t_state     r_state;
    sbbo_pkg::t_state     n_state;
    sbbo_pkg::t_req       r_req;
    sbbo_pkg::t_cell_op   w_op;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_m_tvalid;
    logic [MDAT_W-1:0]    r_m_tdata;
    logic [MDAT_W-1:0]    n_m_tdata;
    logic                 w_out_load;
    logic                 w_accept;
    logic                 w_out_free;
    logic [TAG_W-1:0]     w_tag;
    logic [BIT_W-1:0]     w_bit;
    logic                 w_in_range;
    logic [WORD_BITS-1:0] w_onebit;
    logic [WORD_BITS-1:0] w_match;
    logic                 w_present;
    logic                 w_full;
    logic                 n_bitval;
    logic                 n_status;

    sbbo_pkg::t_cell_stat w_stat [STORE_WORDS];
    logic [TAG_W-1:0]     w_ctag [STORE_WORDS];
    logic [WORD_BITS-1:0] w_cdata [STORE_WORDS];
    logic [STORE_WORDS-1:0] w_valid_vec;
    logic [STORE_WORDS-1:0] w_eq_vec;

    assign s_tready   = (r_state == sbbo_pkg::ST_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_m_tvalid || m_tready;
    assign m_tvalid   = r_m_tvalid;
    assign m_tdata    = r_m_tdata;
    assign w_onebit   = {{(WORD_BITS-1){1'b0}}, 1'b1} << w_bit;
    assign w_present  = w_in_range && (|w_eq_vec);
    assign w_full     = (r_count >= CNT_W'(STORE_WORDS));

    sbbo_split #(
        .WORD_BITS  (WORD_BITS),
        .MASK_WORDS (MASK_WORDS)
    ) u_split (
        .i_clk      (i_clk),
        .i_load     (w_accept),
        .i_idx      (s_tdata[REQ_W +: IDX_W]),
        .o_tag      (w_tag),
        .o_bit      (w_bit),
        .o_in_range (w_in_range)
    );

    for (genvar gi = 0; gi < STORE_WORDS; gi++) begin : g_cell
        sbbo_pkg::t_cell_stat w_prev_stat;
        logic [TAG_W-1:0]     w_prev_tag;
        logic [WORD_BITS-1:0] w_prev_data;
        logic                 w_next_valid;
        logic [TAG_W-1:0]     w_next_tag;
        logic [WORD_BITS-1:0] w_next_data;

        if (gi == 0) begin : g_first
            assign w_prev_stat = '{valid: 1'b1, lt: 1'b1, eq: 1'b0};
            assign w_prev_tag  = '0;
            assign w_prev_data = '0;
        end else begin : g_mid
            assign w_prev_stat = w_stat[gi-1];
            assign w_prev_tag  = w_ctag[gi-1];
            assign w_prev_data = w_cdata[gi-1];
        end

        if (gi == STORE_WORDS - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_tag   = '0;
            assign w_next_data  = '0;
        end else begin : g_inner
            assign w_next_valid = w_stat[gi+1].valid;
            assign w_next_tag   = w_ctag[gi+1];
            assign w_next_data  = w_cdata[gi+1];
        end

        sbbo_cell #(
            .WORD_BITS (WORD_BITS),
            .TAG_W     (TAG_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_pos        (w_tag),
            .i_onebit     (w_onebit),
            .i_prev_stat  (w_prev_stat),
            .i_prev_tag   (w_prev_tag),
            .i_prev_data  (w_prev_data),
            .i_next_valid (w_next_valid),
            .i_next_tag   (w_next_tag),
            .i_next_data  (w_next_data),
            .o_stat       (w_stat[gi]),
            .o_tag        (w_ctag[gi]),
            .o_data       (w_cdata[gi])
        );

        assign w_valid_vec[gi] = w_stat[gi].valid;
        assign w_eq_vec[gi]    = w_stat[gi].eq;
    end

    always_comb begin
        w_match = '0;
        for (int i = 0; i < STORE_WORDS; i++) begin
            if (w_eq_vec[i]) begin
                w_match = w_match | w_cdata[i];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        w_op       = sbbo_pkg::CELL_HOLD;
        w_out_load = 1'b0;
        n_bitval   = 1'b0;
        n_status   = 1'b0;
        case (r_state)
            sbbo_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = sbbo_pkg::ST_DECODE;
                end
            end
            sbbo_pkg::ST_DECODE: begin
                n_state = sbbo_pkg::ST_SPLIT;
            end
            sbbo_pkg::ST_SPLIT: begin
                n_state = sbbo_pkg::ST_EXEC;
            end
            sbbo_pkg::ST_EXEC: begin
                if (w_out_free) begin
                    n_state    = sbbo_pkg::ST_IDLE;
                    w_out_load = 1'b1;
                    case (r_req)
                        sbbo_pkg::REQ_SET: begin
                            if (!w_in_range) begin
                                n_status = 1'b1;
                            end else if (w_present) begin
                                w_op = sbbo_pkg::CELL_OR_BIT;
                            end else if (w_full) begin
                                n_status = 1'b1;
                            end else begin
                                w_op    = sbbo_pkg::CELL_INSERT;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        sbbo_pkg::REQ_CLEAR: begin
                            if (w_present) begin
                                if ((w_match & ~w_onebit) == '0) begin
                                    w_op    = sbbo_pkg::CELL_REMOVE;
                                    n_count = r_count - CNT_W'(1);
                                end else begin
                                    w_op = sbbo_pkg::CELL_AND_NOT;
                                end
                            end
                        end
                        sbbo_pkg::REQ_TEST: begin
                            n_bitval = w_present && w_match[w_bit];
                        end
                        sbbo_pkg::REQ_FLUSH: begin
                            w_op    = sbbo_pkg::CELL_FLUSH;
                            n_count = '0;
                        end
                        default: begin
                            w_op = sbbo_pkg::CELL_HOLD;
                        end
                    endcase
                end
            end
            default: begin
                n_state = sbbo_pkg::ST_IDLE;
            end
        endcase
        n_m_tdata = {WU_W'(n_count), n_status, n_bitval};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sbbo_pkg::ST_IDLE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= sbbo_pkg::t_req'(s_tdata[REQ_W-1:0]);
        end
        if (w_out_load) begin
            r_m_tdata <= n_m_tdata;
        end
    end

`ifndef SYNTHESIS
    a_count_matches_cells : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("word count differs from the number of valid cells");

    a_single_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_eq_vec))
        else $error("more than one cell holds the same word position");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_WORDS))
        else $error("word count exceeds the store depth");
`endif

endmodule

// ===== hdl/sbbo_split.sv =====
// Splits a bit index into word position and bit in word in three register stages.
module sbbo_split #(
    parameter int WORD_BITS  = 64,
    parameter int MASK_WORDS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic [sbbo_pkg::IDX_BITS-1:0]      i_idx,
    output logic [$clog2(MASK_WORDS)-1:0]      o_tag,
    output logic [$clog2(WORD_BITS)-1:0]       o_bit,
    output logic                               o_in_range
);

    localparam int IDX_W   = sbbo_pkg::IDX_BITS;
    localparam int POS_W   = sbbo_pkg::POS_W;
    localparam int TAG_W   = $clog2(MASK_WORDS);
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int SH      = IDX_W + $clog2(WORD_BITS) + 1;
    localparam int RECIP_W = SH - 2;
    localparam int PROD_W  = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SH + WORD_BITS - 1) / WORD_BITS);

    logic [IDX_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_pos;
    logic [PROD_W-1:0] w_prod;
    logic [IDX_W-1:0]  w_base;

    assign w_prod = PROD_W'(r_idx) * PROD_W'(RECIP);
    assign w_base = IDX_W'(r_pos * WORD_BITS);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_idx <= i_idx;
        end
        r_pos      <= w_prod[SH +: POS_W];
        o_bit      <= BIT_W'(r_idx - w_base);
        o_tag      <= r_pos[TAG_W-1:0];
        o_in_range <= (r_pos < POS_W'(MASK_WORDS));
    end

endmodule

// ===== hdl/sbbo_cell.sv =====
// One store cell holding a word, its position tag and a valid bit.
module sbbo_cell #(
    parameter int WORD_BITS = 64,
    parameter int TAG_W     = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sbbo_pkg::t_cell_op    i_op,
    input  logic [TAG_W-1:0]      i_pos,
    input  logic [WORD_BITS-1:0]  i_onebit,
    input  sbbo_pkg::t_cell_stat  i_prev_stat,
    input  logic [TAG_W-1:0]      i_prev_tag,
    input  logic [WORD_BITS-1:0]  i_prev_data,
    input  logic                  i_next_valid,
    input  logic [TAG_W-1:0]      i_next_tag,
    input  logic [WORD_BITS-1:0]  i_next_data,
    output sbbo_pkg::t_cell_stat  o_stat,
    output logic [TAG_W-1:0]      o_tag,
    output logic [WORD_BITS-1:0]  o_data
);

    logic                 r_valid;
    logic                 n_valid;
    logic [TAG_W-1:0]     r_tag;
    logic [TAG_W-1:0]     n_tag;
    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 w_lt;
    logic                 w_eq;

    assign w_lt   = r_valid && (r_tag < i_pos);
    assign w_eq   = r_valid && (r_tag == i_pos);
    assign o_stat = '{valid: r_valid, lt: w_lt, eq: w_eq};
    assign o_tag  = r_tag;
    assign o_data = r_data;

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_data  = r_data;
        case (i_op)
            sbbo_pkg::CELL_OR_BIT: begin
                if (w_eq) begin
                    n_data = r_data | i_onebit;
                end
            end
            sbbo_pkg::CELL_AND_NOT: begin
                if (w_eq) begin
                    n_data = r_data & ~i_onebit;
                end
            end
            sbbo_pkg::CELL_INSERT: begin
                if (!w_lt) begin
                    if (i_prev_stat.lt) begin
                        n_valid = 1'b1;
                        n_tag   = i_pos;
                        n_data  = i_onebit;
                    end else if (i_prev_stat.valid) begin
                        n_valid = 1'b1;
                        n_tag   = i_prev_tag;
                        n_data  = i_prev_data;
                    end
                end
            end
            sbbo_pkg::CELL_REMOVE: begin
                if (r_valid && !w_lt) begin
                    n_valid = i_next_valid;
                    n_tag   = i_next_tag;
                    n_data  = i_next_data;
                end
            end
            sbbo_pkg::CELL_FLUSH: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_data <= n_data;
    end

endmodule

// ===== test/sbbo_result_checker.sv =====
// Result checker for the sparse bitmap bit operations unit: predicts each request and compares.
module sbbo_result_checker #(
    parameter int WORD_BITS   = 64,
    parameter int MASK_WORDS  = 64,
    parameter int STORE_WORDS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [sbbo_pkg::S_DATA_W-1:0]   i_s_tdata,  // req_type, bit_index, zero fill
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [sbbo_pkg::M_DATA_W-1:0]   i_m_tdata,  // bit_value, status, words_used
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sbbo_pkg::WORDS_USED_W-1:0] words_used;
        logic                              status;
        logic                              bit_value;
    } t_result;

    logic [WORD_BITS-1:0]  word_at_pos [MASK_WORDS];
    logic [MASK_WORDS-1:0] held_mask;
    int                    held_count;
    t_result               expected_results [$];
    int                    fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic t_result predict_request(input sbbo_pkg::t_req req,
                                                input logic [sbbo_pkg::IDX_BITS-1:0] idx);
        int      pos;
        int      bitpos;
        t_result res;
        pos    = idx / WORD_BITS;
        bitpos = idx % WORD_BITS;
        res    = '0;
        case (req)
            sbbo_pkg::REQ_SET: begin
                if (pos >= MASK_WORDS) begin
                    res.status = 1'b1;
                end else if (held_mask[pos]) begin
                    word_at_pos[pos][bitpos] = 1'b1;
                end else if (held_count >= STORE_WORDS) begin
                    res.status = 1'b1;
                end else begin
                    word_at_pos[pos]         = '0;
                    word_at_pos[pos][bitpos] = 1'b1;
                    held_mask[pos]           = 1'b1;
                    held_count++;
                end
            end
            sbbo_pkg::REQ_CLEAR: begin
                if (pos < MASK_WORDS && held_mask[pos]) begin
                    word_at_pos[pos][bitpos] = 1'b0;
                    if (word_at_pos[pos] == '0) begin
                        held_mask[pos] = 1'b0;
                        held_count--;
                    end
                end
            end
            sbbo_pkg::REQ_TEST: begin
                if (pos < MASK_WORDS && held_mask[pos]) begin
                    res.bit_value = word_at_pos[pos][bitpos];
                end
            end
            default: begin
                held_mask  = '0;
                held_count = 0;
            end
        endcase
        res.words_used = held_count[sbbo_pkg::WORDS_USED_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            held_mask  = '0;
            held_count = 0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata);
                if (expected_results.size() == 0) begin
                    $error("Result item %h arrived with no request outstanding.", i_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.bit_value !== want.bit_value) begin
                        $error("bit_value: expected %0d, actual %0d", want.bit_value,
                               got.bit_value);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.words_used !== want.words_used) begin
                        $error("words_used: expected %0d, actual %0d", want.words_used,
                               got.words_used);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_request(
                    sbbo_pkg::t_req'(i_s_tdata[sbbo_pkg::REQ_BITS-1:0]),
                    i_s_tdata[sbbo_pkg::REQ_BITS +: sbbo_pkg::IDX_BITS]));
            end
        end
    end

endmodule

// ===== test/sparse_bitmap_bit_ops_unit_tb.sv =====
// Testbench top of the sparse bitmap bit operations unit: clock, reset, stimulus and verdict.
module sparse_bitmap_bit_ops_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_WORD_BITS   = 64;
    localparam int TB_MASK_WORDS  = 64;
    localparam int TB_STORE_WORDS = 32;
    localparam int ITEM_TOTAL     = 450;
    localparam int LONG_HOLD      = 40;
    localparam int IDLE_LIMIT     = 1000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sbbo_pkg::S_DATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sbbo_pkg::M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int items_sent;
    bit quiet;
    bit burst;
    bit long_hold_req;
    bit hold_done;
    bit pause_done;
    int kind;
    int base;
    int r;
    int pos;
    int bitpos;
    sbbo_pkg::t_req req;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sparse_bitmap_bit_ops_unit #(
        .WORD_BITS  (TB_WORD_BITS),
        .MASK_WORDS (TB_MASK_WORDS),
        .STORE_WORDS(TB_STORE_WORDS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    sbbo_result_checker #(
        .WORD_BITS  (TB_WORD_BITS),
        .MASK_WORDS (TB_MASK_WORDS),
        .STORE_WORDS(TB_STORE_WORDS)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic send_item(input sbbo_pkg::t_req kind_of_req, input int index);
        if (!quiet && !burst && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, 12'(index), kind_of_req};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : rx_proc
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready   = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            m_tready = 1'b1;
        end
    end

    initial begin
        items_sent    = 0;
        quiet         = 1'b0;
        burst         = 1'b0;
        long_hold_req = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        i_rst_n       = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners: absent words, repeated sets, word removal, flush.
        send_item(sbbo_pkg::REQ_TEST, 0);
        send_item(sbbo_pkg::REQ_SET, 0);
        send_item(sbbo_pkg::REQ_TEST, 0);
        send_item(sbbo_pkg::REQ_SET, 0);
        send_item(sbbo_pkg::REQ_SET, 4095);
        send_item(sbbo_pkg::REQ_TEST, 4095);
        send_item(sbbo_pkg::REQ_TEST, 4094);
        send_item(sbbo_pkg::REQ_CLEAR, 4094);
        send_item(sbbo_pkg::REQ_CLEAR, 4095);
        send_item(sbbo_pkg::REQ_CLEAR, 4095);
        send_item(sbbo_pkg::REQ_TEST, 4095);
        send_item(sbbo_pkg::REQ_SET, 12'hAAA);
        send_item(sbbo_pkg::REQ_SET, 12'h555);
        send_item(sbbo_pkg::REQ_TEST, 12'hAAA);
        send_item(sbbo_pkg::REQ_TEST, 12'h555);
        send_item(sbbo_pkg::REQ_CLEAR, 0);
        send_item(sbbo_pkg::REQ_FLUSH, 4095);
        send_item(sbbo_pkg::REQ_TEST, 12'h555);
        send_item(sbbo_pkg::REQ_SET, 12'h555);
        send_item(sbbo_pkg::REQ_FLUSH, 0);
        wait_for_drain();

        while (items_sent < ITEM_TOTAL) begin
            if (items_sent >= ITEM_TOTAL - 60) begin
                quiet = 1'b1;
            end
            if (!hold_done && items_sent >= 200) begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                burst         = 1'b1;
                repeat (12) begin
                    send_item(sbbo_pkg::t_req'($urandom_range(0, 2)), $urandom_range(0, 4095));
                end
                burst = 1'b0;
            end
            if (!pause_done && items_sent >= 320) begin
                pause_done = 1'b1;
                wait_for_drain();
            end
            kind = (items_sent < 80) ? 0 : $urandom_range(0, 9);
            if (kind <= 2) begin
                // Fill the store past its capacity with sets spread over all positions.
                repeat ($urandom_range(36, 48)) begin
                    send_item(sbbo_pkg::REQ_SET, $urandom_range(0, 4095));
                end
                repeat ($urandom_range(2, 6)) begin
                    send_item(sbbo_pkg::t_req'($urandom_range(0, 2)), $urandom_range(0, 4095));
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_item(sbbo_pkg::REQ_FLUSH, $urandom_range(0, 4095));
                end
            end else if (kind <= 7) begin
                // Churn a few neighboring words so that clears empty them again.
                base = $urandom_range(0, TB_MASK_WORDS - 4);
                repeat ($urandom_range(10, 30)) begin
                    pos    = base + $urandom_range(0, 3);
                    bitpos = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3)
                                                         : $urandom_range(0, TB_WORD_BITS - 1);
                    r      = $urandom_range(0, 9);
                    req    = (r < 4) ? sbbo_pkg::REQ_SET
                           : (r < 7) ? sbbo_pkg::REQ_CLEAR : sbbo_pkg::REQ_TEST;
                    send_item(req, pos * TB_WORD_BITS + bitpos);
                end
            end else begin
                repeat ($urandom_range(5, 15)) begin
                    send_item(sbbo_pkg::t_req'($urandom_range(0, 3)), $urandom_range(0, 4095));
                end
            end
        end

        wait_for_drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
